[rtl/ert_pkg.sv]
// shared types, constants and helpers for the echo reply tracker
`timescale 1ns / 1ps
`default_nettype none

package ert_pkg;

   localparam int PENDING_DEPTH = 16;
   localparam int IDX_W         = $clog2(PENDING_DEPTH);
   localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);

   localparam int SEQ_W   = 16;
   localparam int TIME_W  = 32;
   localparam int SUM_W   = 48;
   localparam int CNTR_W  = 32;
   localparam int ENTRY_W = SEQ_W + TIME_W;

   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 272;
   localparam int RSP_USER_W = 3;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CMD_SEND  = 2'd0;
   localparam logic [1:0] CMD_REPLY = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_REPLY_MATCH = 3'd1;
   localparam logic [2:0] EV_ERROR_MATCH = 3'd2;
   localparam logic [2:0] EV_TIMED_OUT   = 3'd3;
   localparam logic [2:0] EV_NOT_OURS    = 3'd4;
   localparam logic [2:0] EV_UNKNOWN_SEQ = 3'd5;
   localparam logic [2:0] EV_TABLE_FULL  = 3'd6;

   localparam logic [CSR_ADDR_W-1:0] CSR_IDENT   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 1'd1;

   typedef logic [IDX_W-1:0] slot_idx_type;

   typedef struct packed {
      logic              inc_sent;
      logic              inc_recv;
      logic              inc_lost;
      logic              set_err;
      logic [TIME_W-1:0] trip;
      logic [15:0]       err_tc;
   } stats_upd_type;

   typedef struct packed {
      logic [CNTR_W-1:0] sent;
      logic [CNTR_W-1:0] recv;
      logic [CNTR_W-1:0] lost;
      logic [TIME_W-1:0] min_shown;
      logic [TIME_W-1:0] max;
      logic [SUM_W-1:0]  total;
      logic [15:0]       err_tc;
   } stats_type;

   function automatic slot_idx_type slot_next(input slot_idx_type i);
      if (i == slot_idx_type'(PENDING_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

endpackage

`default_nettype wire

[rtl/ert_ram.sv]
// simple dual-port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ert_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/ert_stats.sv]
// running totals, round-trip sum, minimum and maximum, last error type and code
`timescale 1ns / 1ps
`default_nettype none

module ert_stats (
   input  logic                  clock,
   input  logic                  reset,
   input  ert_pkg::stats_upd_type upd,
   output ert_pkg::stats_type     stats
);

   import ert_pkg::*;

   logic [CNTR_W-1:0] sent_ff, sent_in;
   logic [CNTR_W-1:0] recv_ff, recv_in;
   logic [CNTR_W-1:0] lost_ff, lost_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic [TIME_W-1:0] max_ff, max_in;
   logic [15:0]       err_tc_ff, err_tc_in;
   logic [SUM_W:0]    sum_ext;

   assign sum_ext = {1'b0, sum_ff} + (SUM_W + 1)'(upd.trip);

   always_comb begin
      sent_in   = sent_ff;
      recv_in   = recv_ff;
      lost_in   = lost_ff;
      sum_in    = sum_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      err_tc_in = err_tc_ff;
      if (upd.inc_sent) begin
         sent_in = sent_ff + 1'b1;
      end
      if (upd.inc_lost) begin
         lost_in = lost_ff + 1'b1;
      end
      if (upd.set_err) begin
         err_tc_in = upd.err_tc;
      end
      if (upd.inc_recv) begin
         recv_in = recv_ff + 1'b1;
         sum_in  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
         if (upd.trip < min_ff) begin
            min_in = upd.trip;
         end
         if (upd.trip > max_ff) begin
            max_in = upd.trip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff   <= '0;
         recv_ff   <= '0;
         lost_ff   <= '0;
         sum_ff    <= '0;
         min_ff    <= '1;
         max_ff    <= '0;
         err_tc_ff <= '0;
      end else begin
         sent_ff   <= sent_in;
         recv_ff   <= recv_in;
         lost_ff   <= lost_in;
         sum_ff    <= sum_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         err_tc_ff <= err_tc_in;
      end
   end

   always_comb begin
      stats.sent      = sent_ff;
      stats.recv      = recv_ff;
      stats.lost      = lost_ff;
      stats.min_shown = (recv_ff == '0 && min_ff == '1) ? '0 : min_ff;
      stats.max       = max_ff;
      stats.total     = sum_ff;
      stats.err_tc    = err_tc_ff;
   end

endmodule

`default_nettype wire

[rtl/echo_reply_tracker.sv]
// top level: echo request tracking sequencer around the pending-request ram
// One transaction is handled at a time. A send, an unused command, a reply that
// is not ours and a tick with an empty table go straight to the head walk and the
// output step; any other tick first checks the age of the oldest pending slot,
// and a searched reply first runs the sequence search, which reads one pending
// slot per cycle from the ram. The head walk steps one slot per cycle to the
// oldest occupied slot. The result is held in an output register; a new request
// is taken once it has been loaded, and the last step waits while the previous
// result has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module echo_reply_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // seq, now_ms, echoed_ms, reply_id, err_type, err_code
   input  logic [ert_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd, is_error
   input  logic [ert_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // event_seq, trip_ms, sent_count, received_count, lost_count, min_ms,
   // max_ms, total_ms, last_type, last_code
   output logic [ert_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // event_res
   output logic [ert_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             csr_we,
   input  logic [ert_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ert_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import ert_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_TICK,
      ST_SETTLE,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [15:0]              ident_ff, ident_in;
   logic [TIME_W-1:0]        timeout_ff, timeout_in;
   logic                     is_err_ff, is_err_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [TIME_W-1:0]        trip_ff, trip_in;
   logic [15:0]              err_tc_ff, err_tc_in;
   logic [PENDING_DEPTH-1:0] pend_valid_ff, pend_valid_in;
   slot_idx_type             head_ff, head_in;
   slot_idx_type             tail_ff, tail_in;
   slot_idx_type             scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                     rd_vld_ff, rd_vld_in;
   slot_idx_type             rd_idx_ff, rd_idx_in;
   logic                     rd_last_ff, rd_last_in;
   logic [CNT_W-1:0]         settle_cnt_ff, settle_cnt_in;
   logic [2:0]               ev_ff, ev_in;
   logic [SEQ_W-1:0]         ev_seq_ff, ev_seq_in;
   logic [TIME_W-1:0]        ev_trip_ff, ev_trip_in;
   stats_upd_type            upd_ff, upd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]    rsp_user_ff, rsp_user_in;

   logic                     ram_we;
   logic                     ram_re;
   slot_idx_type             ram_raddr;
   logic [ENTRY_W-1:0]       ram_wdata;
   logic [ENTRY_W-1:0]       ram_rdata;
   logic [SEQ_W-1:0]         ram_q_seq;
   logic [TIME_W-1:0]        ram_q_time;
   stats_type                stats;

   logic [1:0]               req_cmd;
   logic [SEQ_W-1:0]         req_seq;
   logic [TIME_W-1:0]        req_now;
   logic [TIME_W-1:0]        req_echoed;
   logic                     req_is_err;
   logic [15:0]              req_rid;
   logic [7:0]               req_etype;
   logic [7:0]               req_ecode;
   logic                     accept;
   logic                     hit;
   logic [TIME_W-1:0]        age;

   assign req_cmd    = req_tuser[1:0];
   assign req_is_err = req_tuser[2];
   assign req_seq    = req_tdata[15:0];
   assign req_now    = req_tdata[47:16];
   assign req_echoed = req_tdata[79:48];
   assign req_rid    = req_tdata[95:80];
   assign req_etype  = req_tdata[103:96];
   assign req_ecode  = req_tdata[111:104];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign ram_q_seq  = ram_rdata[ENTRY_W-1:TIME_W];
   assign ram_q_time = ram_rdata[TIME_W-1:0];
   assign ram_wdata  = {req_seq, req_now};

   assign hit = rd_vld_ff && pend_valid_ff[rd_idx_ff] && (ram_q_seq == seq_ff);
   assign age = now_ff - ram_q_time;

   ert_ram #(
      .DEPTH (PENDING_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_pending_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ert_stats u_stats (
      .clock (clock),
      .reset (reset),
      .upd   (upd_ff),
      .stats (stats)
   );

   always_comb begin
      state_in      = state_ff;
      ident_in      = ident_ff;
      timeout_in    = timeout_ff;
      is_err_in     = is_err_ff;
      seq_in        = seq_ff;
      now_in        = now_ff;
      trip_in       = trip_ff;
      err_tc_in     = err_tc_ff;
      pend_valid_in = pend_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      scan_idx_in   = scan_idx_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rd_last_in    = 1'b0;
      settle_cnt_in = settle_cnt_ff;
      ev_in         = ev_ff;
      ev_seq_in     = ev_seq_ff;
      ev_trip_in    = ev_trip_ff;
      upd_in        = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = head_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_IDENT:   ident_in   = csr_wdata[15:0];
            CSR_TIMEOUT: timeout_in = csr_wdata[TIME_W-1:0];
            default:     ident_in   = ident_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            settle_cnt_in = '0;
            if (accept) begin
               seq_in     = req_seq;
               now_in     = req_now;
               is_err_in  = req_is_err;
               trip_in    = req_now - req_echoed;
               err_tc_in  = {req_etype, req_ecode};
               ev_in      = EV_NONE;
               ev_seq_in  = '0;
               ev_trip_in = '0;
               state_in   = ST_SETTLE;
               case (req_cmd)
                  CMD_SEND: begin
                     ev_seq_in       = req_seq;
                     upd_in.inc_sent = 1'b1;
                     if (pend_valid_ff[tail_ff]) begin
                        ev_in           = EV_TABLE_FULL;
                        upd_in.inc_lost = 1'b1;
                     end else begin
                        ram_we                 = 1'b1;
                        pend_valid_in[tail_ff] = 1'b1;
                        tail_in                = slot_next(tail_ff);
                     end
                  end
                  CMD_REPLY: begin
                     ev_seq_in = req_seq;
                     if (req_rid != ident_ff) begin
                        ev_in = EV_NOT_OURS;
                     end else begin
                        scan_idx_in = head_ff;
                        scan_cnt_in = '0;
                        state_in    = ST_SEARCH;
                     end
                  end
                  CMD_TICK: begin
                     if (pend_valid_ff[head_ff]) begin
                        ram_re   = 1'b1;
                        state_in = ST_TICK;
                     end
                  end
                  default: begin
                     state_in = ST_SETTLE;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            if (hit) begin
               pend_valid_in[rd_idx_ff] = 1'b0;
               state_in                 = ST_SETTLE;
               if (is_err_ff) begin
                  ev_in           = EV_ERROR_MATCH;
                  upd_in.inc_lost = 1'b1;
                  upd_in.set_err  = 1'b1;
                  upd_in.err_tc   = err_tc_ff;
               end else begin
                  ev_in           = EV_REPLY_MATCH;
                  ev_trip_in      = trip_ff;
                  upd_in.inc_recv = 1'b1;
                  upd_in.trip     = trip_ff;
               end
            end else if (rd_vld_ff && rd_last_ff) begin
               ev_in          = EV_UNKNOWN_SEQ;
               upd_in.set_err = is_err_ff;
               upd_in.err_tc  = err_tc_ff;
               state_in       = ST_SETTLE;
            end else if (scan_cnt_ff < CNT_W'(PENDING_DEPTH)) begin
               ram_re      = 1'b1;
               ram_raddr   = scan_idx_ff;
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_idx_ff;
               rd_last_in  = (scan_cnt_ff == CNT_W'(PENDING_DEPTH - 1));
               scan_idx_in = slot_next(scan_idx_ff);
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end

         ST_TICK: begin
            state_in = ST_SETTLE;
            if (age >= timeout_ff) begin
               ev_in                  = EV_TIMED_OUT;
               ev_seq_in              = ram_q_seq;
               pend_valid_in[head_ff] = 1'b0;
               upd_in.inc_lost        = 1'b1;
            end
         end

         ST_SETTLE: begin
            if (pend_valid_ff == '0) begin
               head_in  = tail_ff;
               state_in = ST_EMIT;
            end else if (pend_valid_ff[head_ff]) begin
               state_in = ST_EMIT;
            end else if (settle_cnt_ff == CNT_W'(PENDING_DEPTH - 1)) begin
               head_in  = tail_ff;
               state_in = ST_EMIT;
            end else begin
               head_in       = slot_next(head_ff);
               settle_cnt_in = settle_cnt_ff + 1'b1;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = ev_ff;
               rsp_data_in  = {stats.err_tc[7:0], stats.err_tc[15:8], stats.total,
                               stats.max, stats.min_shown, stats.lost, stats.recv,
                               stats.sent, ev_trip_ff, ev_seq_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ident_ff      <= '0;
         timeout_ff    <= '0;
         pend_valid_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         scan_cnt_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         settle_cnt_ff <= '0;
         upd_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ident_ff      <= ident_in;
         timeout_ff    <= timeout_in;
         pend_valid_ff <= pend_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         scan_cnt_ff   <= scan_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         settle_cnt_ff <= settle_cnt_in;
         upd_ff        <= upd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      is_err_ff   <= is_err_in;
      seq_ff      <= seq_in;
      now_ff      <= now_in;
      trip_ff     <= trip_in;
      err_tc_ff   <= err_tc_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      ev_ff       <= ev_in;
      ev_seq_ff   <= ev_seq_in;
      ev_trip_ff  <= ev_trip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in flight");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the emit step");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= CNT_W'(PENDING_DEPTH))
      else $error("sequence search ran past the table");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && pend_valid_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty table with head apart from tail");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_echo_reply_tracker.sv]
// testbench for the echo reply tracker: directed and random transactions against a predictor
`timescale 1ns / 1ps
module tb_echo_reply_tracker;
   import ert_pkg::*;

   localparam logic [1:0]       CMD_UNUSED    = 2'd3;
   localparam int               SETTLE_CYCLES = 2 * PENDING_DEPTH + 8;
   localparam int               PHASE_ITEMS   = 80;
   localparam logic [SUM_W-1:0] SUM_CEIL      = {SUM_W{1'b1}};

   typedef struct packed {
      logic        is_err;
      logic [1:0]  cmd;
      logic [7:0]  err_code;
      logic [7:0]  err_type;
      logic [15:0] reply_id;
      logic [31:0] echoed_ms;
      logic [31:0] now_ms;
      logic [15:0] seq;
   } echo_item_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  last_code;
      logic [7:0]  last_type;
      logic [47:0] total_ms;
      logic [31:0] max_ms;
      logic [31:0] min_ms;
      logic [31:0] lost_count;
      logic [31:0] received_count;
      logic [31:0] sent_count;
      logic [31:0] trip_ms;
      logic [15:0] event_seq;
   } echo_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // seq, now_ms, echoed_ms, reply_id, err_type, err_code
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // cmd, is_error
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // event_seq, trip_ms, sent_count, received_count, lost_count, min_ms,
   // max_ms, total_ms, last_type, last_code
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // event_res
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [15:0] slot_seq  [PENDING_DEPTH];
   logic [31:0] slot_time [PENDING_DEPTH];
   logic        slot_busy [PENDING_DEPTH];
   int          oldest_slot;
   int          free_slot;
   logic [31:0] sent_total;
   logic [31:0] recv_total;
   logic [31:0] lost_total;
   logic [31:0] trip_lo;
   logic [31:0] trip_hi;
   logic [47:0] trip_sum;
   logic [15:0] last_err;
   logic [15:0] cfg_ident;
   logic [31:0] cfg_timeout;

   echo_result_type echo_result_q[$];
   int              fail_count = 0;
   bit              idle_on = 1'b1;
   int              rsp_hold_left = 0;
   int              rsp_stall_left = 0;
   logic [31:0]     stim_ms = '0;
   logic [15:0]     seq_ctr = '0;

   echo_reply_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int ring_next(input int i);
      return (i + 1 >= PENDING_DEPTH) ? 0 : i + 1;
   endfunction

   // walk to the oldest occupied slot, or to the write slot when empty
   function automatic void settle_oldest();
      int k;
      for (k = 0; k < PENDING_DEPTH; k++) begin
         if (slot_busy[oldest_slot]) begin
            return;
         end
         oldest_slot = ring_next(oldest_slot);
      end
      oldest_slot = free_slot;
   endfunction

   function automatic void reset_tracker_model();
      int k;
      for (k = 0; k < PENDING_DEPTH; k++) begin
         slot_seq[k]  = '0;
         slot_time[k] = '0;
         slot_busy[k] = 1'b0;
      end
      oldest_slot = 0;
      free_slot   = 0;
      sent_total  = '0;
      recv_total  = '0;
      lost_total  = '0;
      trip_sum    = '0;
      trip_lo     = '1;
      trip_hi     = '0;
      last_err    = '0;
      cfg_ident   = '0;
      cfg_timeout = '0;
   endfunction

   function automatic echo_result_type track_echo(input echo_item_type it);
      echo_result_type r;
      int              i;
      int              k;
      bit              found;
      logic [48:0]     wide_sum;
      logic [31:0]     trip;
      logic [31:0]     age;
      r     = '0;
      found = 1'b0;
      trip  = '0;
      case (it.cmd)
         CMD_SEND: begin
            r.event_seq = it.seq;
            sent_total++;
            if (slot_busy[free_slot]) begin
               lost_total++;
               r.event_res = EV_TABLE_FULL;
            end else begin
               slot_seq[free_slot]  = it.seq;
               slot_time[free_slot] = it.now_ms;
               slot_busy[free_slot] = 1'b1;
               free_slot = ring_next(free_slot);
               settle_oldest();
            end
         end
         CMD_REPLY: begin
            r.event_seq = it.seq;
            if (it.reply_id != cfg_ident) begin
               r.event_res = EV_NOT_OURS;
            end else begin
               if (it.is_err) begin
                  last_err = {it.err_type, it.err_code};
               end
               i = oldest_slot;
               for (k = 0; k < PENDING_DEPTH && !found; k++) begin
                  if (slot_busy[i] && slot_seq[i] == it.seq) begin
                     found = 1'b1;
                  end else begin
                     i = ring_next(i);
                  end
               end
               if (!found) begin
                  r.event_res = EV_UNKNOWN_SEQ;
               end else begin
                  slot_busy[i] = 1'b0;
                  settle_oldest();
                  if (it.is_err) begin
                     lost_total++;
                     r.event_res = EV_ERROR_MATCH;
                  end else begin
                     trip = it.now_ms - it.echoed_ms;
                     recv_total++;
                     wide_sum = {1'b0, trip_sum} + {17'b0, trip};
                     trip_sum = (wide_sum > {1'b0, SUM_CEIL}) ? SUM_CEIL : wide_sum[47:0];
                     if (trip < trip_lo) begin
                        trip_lo = trip;
                     end
                     if (trip > trip_hi) begin
                        trip_hi = trip;
                     end
                     r.event_res = EV_REPLY_MATCH;
                  end
               end
            end
         end
         CMD_TICK: begin
            age = it.now_ms - slot_time[oldest_slot];
            if (slot_busy[oldest_slot] && age >= cfg_timeout) begin
               r.event_seq = slot_seq[oldest_slot];
               slot_busy[oldest_slot] = 1'b0;
               settle_oldest();
               lost_total++;
               r.event_res = EV_TIMED_OUT;
            end
         end
         default: begin
         end
      endcase
      r.trip_ms        = trip;
      r.sent_count     = sent_total;
      r.received_count = recv_total;
      r.lost_count     = lost_total;
      r.min_ms         = (recv_total == '0 && trip_lo == '1) ? '0 : trip_lo;
      r.max_ms         = trip_hi;
      r.total_ms       = trip_sum;
      r.last_type      = last_err[15:8];
      r.last_code      = last_err[7:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_busy_slot();
      int busy[$];
      int k;
      for (k = 0; k < PENDING_DEPTH; k++) begin
         if (slot_busy[k]) begin
            busy = {busy, k};
         end
      end
      if (busy.size() == 0) begin
         return -1;
      end
      return busy[$urandom_range(0, busy.size() - 1)];
   endfunction

   function automatic echo_item_type make_item(input logic [1:0] cmd, input logic [15:0] seq,
                                               input logic [31:0] now, input logic [31:0] echoed,
                                               input logic is_err, input logic [15:0] rid,
                                               input logic [7:0] etype, input logic [7:0] ecode);
      echo_item_type it;
      it.cmd       = cmd;
      it.seq       = seq;
      it.now_ms    = now;
      it.echoed_ms = echoed;
      it.is_err    = is_err;
      it.reply_id  = rid;
      it.err_type  = etype;
      it.err_code  = ecode;
      return it;
   endfunction

   // mostly well-formed traffic: sends, replies to pending requests and ticks
   function automatic echo_item_type random_echo_item();
      echo_item_type it;
      logic [127:0]  raw;
      logic [15:0]   flip;
      int            r;
      int            k;
      raw = {$urandom, $urandom, $urandom, $urandom};
      it  = raw[114:0];
      stim_ms += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, 30);
      r = $urandom_range(0, 99);
      if (r < 34) begin
         it.cmd    = CMD_SEND;
         it.now_ms = stim_ms;
         k = pick_busy_slot();
         if (k >= 0 && $urandom_range(0, 19) == 0) begin
            it.seq = slot_seq[k];
         end else if ($urandom_range(0, 3) != 0) begin
            it.seq = seq_ctr;
            seq_ctr++;
         end
      end else if (r < 68) begin
         it.cmd      = CMD_REPLY;
         it.now_ms   = stim_ms;
         it.reply_id = cfg_ident;
         it.is_err   = ($urandom_range(0, 6) == 0);
         k = pick_busy_slot();
         if (k >= 0) begin
            it.seq = slot_seq[k];
            if ($urandom_range(0, 9) != 0) begin
               it.echoed_ms = slot_time[k];
            end
         end
      end else if (r < 82) begin
         it.cmd    = CMD_TICK;
         it.now_ms = stim_ms;
      end else if (r < 88) begin
         flip        = 16'($urandom_range(1, 65535));
         it.cmd      = CMD_REPLY;
         it.reply_id = cfg_ident ^ flip;
      end else if (r < 94) begin
         it.cmd      = CMD_REPLY;
         it.reply_id = cfg_ident;
      end else if (r < 97) begin
         it.cmd = CMD_UNUSED;
      end
      return it;
   endfunction

   task automatic send_item(input echo_item_type it);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      {req_tuser, req_tdata} = it;
      req_tvalid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      echo_result_q = {echo_result_q, track_echo(it)};
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (echo_result_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input logic [15:0] id, input logic [31:0] tmo);
      logic [31:0] wdata;
      wait_results_done();
      wdata       = $urandom;
      wdata[15:0] = id;
      write_reg(CSR_IDENT, wdata);
      cfg_ident = id;
      write_reg(CSR_TIMEOUT, tmo);
      cfg_timeout = tmo;
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic test_table_fill();
      int k;
      set_config(16'hA5C3, 32'd0);
      stim_ms = 32'd1000;
      for (k = 0; k < PENDING_DEPTH; k++) begin
         send_item(make_item(CMD_SEND, 16'(16'h0100 + k), stim_ms + 32'(k), 32'h0, 1'b0,
                             16'h0, 8'h0, 8'h0));
      end
      // table full
      send_item(make_item(CMD_SEND, 16'h0200, 32'd1017, 32'hFFFF_FFFF, 1'b1, 16'hFFFF,
                          8'hFF, 8'hFF));
   endtask

   task automatic test_reply_cases();
      // zero round trip
      send_item(make_item(CMD_REPLY, 16'h0105, 32'd1020, 32'd1020, 1'b0, cfg_ident,
                          8'h0, 8'h0));
      // slot freed out of order, write slot still occupied
      send_item(make_item(CMD_SEND, 16'h0201, 32'd1020, 32'h0, 1'b0, 16'h0, 8'h0, 8'h0));
      // largest round trip
      send_item(make_item(CMD_REPLY, 16'h0106, 32'd1021, 32'd1022, 1'b0, cfg_ident,
                          8'h0, 8'h0));
      send_item(make_item(CMD_REPLY, 16'h0107, 32'd1022, 32'd1000, 1'b1, cfg_ident,
                          8'd3, 8'd1));
      // error with our id but unknown sequence
      send_item(make_item(CMD_REPLY, 16'hBEEF, 32'd1023, 32'd0, 1'b1, cfg_ident,
                          8'd11, 8'd0));
      send_item(make_item(CMD_REPLY, 16'h0109, 32'd1024, 32'd1009, 1'b0,
                          cfg_ident ^ 16'hFFFF, 8'h0, 8'h0));
      send_item(make_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                          16'hFFFF, 8'hFF, 8'hFF));
   endtask

   task automatic test_tick_and_duplicate();
      // zero timeout expires the oldest at once
      send_item(make_item(CMD_TICK, 16'h0, 32'd1030, 32'h0, 1'b0, 16'h0, 8'h0, 8'h0));
      send_item(make_item(CMD_SEND, 16'h0108, 32'd1031, 32'h0, 1'b0, 16'h0, 8'h0, 8'h0));
      // duplicate sequence retires the older entry
      send_item(make_item(CMD_REPLY, 16'h0108, 32'd1040, 32'd1008, 1'b0, cfg_ident,
                          8'h0, 8'h0));
      send_item(make_item(CMD_REPLY, 16'h0108, 32'd1041, 32'd1031, 1'b0, cfg_ident,
                          8'h0, 8'h0));
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      rsp_hold_left = 300;
      repeat (24) send_item(random_echo_item());
      wait_results_done();
      idle_on = 1'b1;
      repeat (8) send_item(random_echo_item());
   endtask

   task automatic test_random_traffic();
      int ph;
      for (ph = 0; ph < 6; ph++) begin
         idle_on = (ph % 3 != 0);
         case (ph)
            0: set_config(16'h0000, 32'd0);
            1: set_config(16'hFFFF, 32'hFFFF_FFFF);
            2: set_config(16'($urandom), 32'd40);
            3: begin
               stim_ms = 32'hFFFF_FF00;
               set_config(16'($urandom), 32'd200);
            end
            4: set_config(16'($urandom), $urandom_range(1, 1000));
            default: set_config(16'($urandom), 32'd0);
         endcase
         repeat (PHASE_ITEMS) send_item(random_echo_item());
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_tready = 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_tready = 1'b1;
            rsp_stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      echo_result_type want;
      echo_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (echo_result_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none got event_res %0d event_seq %0h",
                     $time, got.event_res, got.event_seq);
            fail_count++;
         end else begin
            want = echo_result_q[0];
            echo_result_q.delete(0);
            check_field("event_res", 48'(want.event_res), 48'(got.event_res));
            check_field("event_seq", 48'(want.event_seq), 48'(got.event_seq));
            check_field("trip_ms", 48'(want.trip_ms), 48'(got.trip_ms));
            check_field("sent_count", 48'(want.sent_count), 48'(got.sent_count));
            check_field("received_count", 48'(want.received_count),
                        48'(got.received_count));
            check_field("lost_count", 48'(want.lost_count), 48'(got.lost_count));
            check_field("min_ms", 48'(want.min_ms), 48'(got.min_ms));
            check_field("max_ms", 48'(want.max_ms), 48'(got.max_ms));
            check_field("total_ms", want.total_ms, got.total_ms);
            check_field("last_type", 48'(want.last_type), 48'(got.last_type));
            check_field("last_code", 48'(want.last_code), 48'(got.last_code));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset_tracker_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_table_fill();
      test_reply_cases();
      test_tick_and_duplicate();
      test_backpressure();
      test_random_traffic();
      wait_results_done();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
